FILE: rtl/pba_pkg.sv
// ============================================================================
// pba_pkg
// Shared types and constants of the prefill batch admission block.
// ============================================================================
package pba_pkg;

  localparam int unsigned IdxW    = 16;
  localparam int unsigned RepW    = 8;
  localparam int unsigned TokW    = 20;
  localparam int unsigned TotW    = 40;
  localparam int unsigned CntW    = 10;
  localparam int unsigned HintW   = 21;
  localparam int unsigned LimW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned InDatW  = 88;
  localparam int unsigned OutDatW = 112;
  localparam int unsigned OutUsrW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegOwnReplica   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRequestLimit = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTokenLimit   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegChunkEnable  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegChunkSize    = 3'd4;

  localparam logic [RepW-1:0] OwnReplicaRst   = '0;
  localparam logic [CntW-1:0] RequestLimitRst = 10'd1;
  localparam logic [LimW-1:0] TokenLimitRst   = '0;
  localparam logic [TokW-1:0] ChunkSizeRst    = 20'd512;

  localparam logic [TotW-1:0] TotMax = '1;

  // One result word.
  typedef struct packed {
    logic             admitted;
    logic [IdxW-1:0]  granted_index;
    logic [TokW-1:0]  granted_tokens;
    logic [TotW-1:0]  batch_tokens;
    logic [CntW-1:0]  batch_count;
    logic [HintW-1:0] length_hint;
    logic             batch_closed;
    logic             batch_empty;
  } result_t;

endpackage

FILE: rtl/prefill_batch_admission.sv
// ============================================================================
// prefill_batch_admission
// Greedy admission of candidate requests into one prefill batch.
// ============================================================================
// The block takes one candidate request per word on the in_ stream and
// returns one result word per candidate on the out_ stream, in order. Each
// candidate is decided in the cycle it is accepted: a single add, compare
// and max against the running batch state, which is written back at the
// same clock edge, so a new candidate can be accepted every cycle while
// the skid register is empty. A two-deep output stage (result register plus
// skid register) lets the block keep accepting while the result side
// stalls; in_tready is the registered inverse of skid_valid_r. Configuration
// is written through the cfg_ port; the user must write it only while the
// block is idle (not enforced here). It takes effect on the next candidate.
// ============================================================================
module prefill_batch_admission (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [pba_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [pba_pkg::CfgDatW-1:0]      cfg_wdata,
  // Candidate stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, from bit 0: req_index[15:0], req_replica[23:16], req_finished[24],
  // req_busy[25], req_remaining[45:26], req_prompt[65:46],
  // req_done_out[85:66], zero fill[87:86].
  input  logic [pba_pkg::InDatW-1:0]       in_tdata,
  input  logic                             in_tlast,   // final_candidate
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, from bit 0: granted_index[15:0], granted_tokens[35:16],
  // batch_tokens[75:36], batch_count[85:76], length_hint[106:86],
  // zero fill[111:107].
  output logic [pba_pkg::OutDatW-1:0]      out_tdata,
  // tuser, from bit 0: admitted[0], batch_empty[1].
  output logic [pba_pkg::OutUsrW-1:0]      out_tuser,
  output logic                             out_tlast   // batch_closed
);

  // Configuration registers.
  logic [pba_pkg::RepW-1:0] own_replica_r;
  logic [pba_pkg::CntW-1:0] request_limit_r;
  logic [pba_pkg::LimW-1:0] token_limit_r;
  logic                     chunk_enable_r;
  logic [pba_pkg::TokW-1:0] chunk_size_r;

  // Running batch state.
  logic [pba_pkg::TotW-1:0]  token_total_r, token_total_nxt;
  logic [pba_pkg::CntW-1:0]  admit_count_r, admit_count_nxt;
  logic [pba_pkg::HintW-1:0] hint_max_r, hint_max_nxt;
  logic                      batch_full_r, batch_full_nxt;

  // Output stage.
  pba_pkg::result_t out_r, out_nxt, skid_r, skid_nxt, res;
  logic             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  // Unpacked candidate fields.
  logic [pba_pkg::IdxW-1:0] req_index;
  logic [pba_pkg::RepW-1:0] req_replica;
  logic                     req_finished, req_busy;
  logic [pba_pkg::TokW-1:0] req_remaining, req_prompt, req_done_out;

  logic                       in_acc;
  logic                       eligible, admit, hit_limit, closed;
  logic [pba_pkg::TokW-1:0]   grant;
  logic [pba_pkg::TotW:0]     sum;
  logic [pba_pkg::TotW-1:0]   total_new;
  logic [pba_pkg::CntW-1:0]   count_new, lim;
  logic [pba_pkg::HintW-1:0]  len, hint_new;

  assign req_index     = in_tdata[15:0];
  assign req_replica   = in_tdata[23:16];
  assign req_finished  = in_tdata[24];
  assign req_busy      = in_tdata[25];
  assign req_remaining = in_tdata[45:26];
  assign req_prompt    = in_tdata[65:46];
  assign req_done_out  = in_tdata[85:66];

  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;

  // Admission decision for the candidate on the input.
  always_comb begin
    eligible = (req_replica == own_replica_r) & ~req_finished & ~req_busy &
               (req_remaining != '0);
    grant = req_remaining;
    if (chunk_enable_r && (chunk_size_r < req_remaining)) begin
      grant = chunk_size_r;
    end
    // The sum is one bit wider so the budget check and saturation see carry.
    sum = {1'b0, token_total_r} + {{(pba_pkg::TotW + 1 - pba_pkg::TokW){1'b0}}, grant};
    admit = eligible & ((admit_count_r == '0) | (token_limit_r == '0) |
            (sum <= {{(pba_pkg::TotW + 1 - pba_pkg::LimW){1'b0}}, token_limit_r}));
    if (!admit) begin
      grant = '0;
    end

    len       = {1'b0, req_prompt} + {1'b0, req_done_out};
    total_new = token_total_r;
    count_new = admit_count_r;
    hint_new  = hint_max_r;
    if (admit) begin
      total_new = sum[pba_pkg::TotW] ? pba_pkg::TotMax : sum[pba_pkg::TotW-1:0];
      count_new = admit_count_r + {{(pba_pkg::CntW-1){1'b0}}, 1'b1};
      if (len > hint_max_r) begin
        hint_new = len;
      end
    end
    lim       = (request_limit_r == '0) ? {{(pba_pkg::CntW-1){1'b0}}, 1'b1}
                                        : request_limit_r;
    hit_limit = admit & (count_new >= lim);
    closed    = hit_limit | in_tlast;

    res.granted_index = req_index;
    if (batch_full_r) begin
      // A full batch ignores candidates until the final one of the list.
      res.admitted       = 1'b0;
      res.granted_tokens = '0;
      res.batch_tokens   = '0;
      res.batch_count    = '0;
      res.length_hint    = '0;
      res.batch_closed   = 1'b0;
      res.batch_empty    = 1'b0;
      token_total_nxt    = token_total_r;
      admit_count_nxt    = admit_count_r;
      hint_max_nxt       = hint_max_r;
      batch_full_nxt     = ~in_tlast;
    end else begin
      res.admitted       = admit;
      res.granted_tokens = grant;
      res.batch_tokens   = total_new;
      res.batch_count    = count_new;
      res.length_hint    = hint_new;
      res.batch_closed   = closed;
      res.batch_empty    = closed & (count_new == '0);
      if (closed) begin
        token_total_nxt = '0;
        admit_count_nxt = '0;
        hint_max_nxt    = '0;
        batch_full_nxt  = hit_limit & ~in_tlast;
      end else begin
        token_total_nxt = total_new;
        admit_count_nxt = count_new;
        hint_max_nxt    = hint_new;
        batch_full_nxt  = 1'b0;
      end
    end
  end

  // Output and skid registers: a result lands in the output register when it
  // is free or draining this cycle, otherwise in the skid register.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_tready) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_replica_r   <= pba_pkg::OwnReplicaRst;
      request_limit_r <= pba_pkg::RequestLimitRst;
      token_limit_r   <= pba_pkg::TokenLimitRst;
      chunk_enable_r  <= 1'b0;
      chunk_size_r    <= pba_pkg::ChunkSizeRst;
      token_total_r   <= '0;
      admit_count_r   <= '0;
      hint_max_r      <= '0;
      batch_full_r    <= 1'b0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pba_pkg::RegOwnReplica:   own_replica_r   <= cfg_wdata[pba_pkg::RepW-1:0];
          pba_pkg::RegRequestLimit: request_limit_r <= cfg_wdata[pba_pkg::CntW-1:0];
          pba_pkg::RegTokenLimit:   token_limit_r   <= cfg_wdata[pba_pkg::LimW-1:0];
          pba_pkg::RegChunkEnable:  chunk_enable_r  <= cfg_wdata[0];
          pba_pkg::RegChunkSize:    chunk_size_r    <= cfg_wdata[pba_pkg::TokW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        token_total_r <= token_total_nxt;
        admit_count_r <= admit_count_nxt;
        hint_max_r    <= hint_max_nxt;
        batch_full_r  <= batch_full_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.length_hint, out_r.batch_count, out_r.batch_tokens,
                       out_r.granted_tokens, out_r.granted_index};
  assign out_tuser  = {out_r.batch_empty, out_r.admitted};
  assign out_tlast  = out_r.batch_closed;

endmodule

FILE: tb/admission_checker.sv
// ============================================================================
// admission_checker
// Predicts and checks every result word of the prefill batch admission block.
// ============================================================================
// The checker watches the configuration port and both stream channels. It
// keeps its own copy of the registers and of the running batch state. For
// each candidate word accepted on the input it works out the result word
// and queues it. Each result word accepted on the output is then compared,
// field by field, with the oldest queued word.
// ============================================================================
module admission_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pba_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pba_pkg::CfgDatW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [pba_pkg::InDatW-1:0]  in_tdata,
  input  logic                        in_tlast,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [pba_pkg::OutDatW-1:0] out_tdata,
  input  logic [pba_pkg::OutUsrW-1:0] out_tuser,
  input  logic                        out_tlast,
  output int                          mismatch_count,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int MaxPrinted = 40;

  // Candidate word as it sits on in_tdata, highest field first.
  typedef struct packed {
    logic [1:0]      fill;
    logic [TokW-1:0] done_out;
    logic [TokW-1:0] prompt;
    logic [TokW-1:0] remaining;
    logic            busy;
    logic            finished;
    logic [RepW-1:0] replica;
    logic [IdxW-1:0] index;
  } candidate_t;

  logic [RepW-1:0]  own_rep;
  logic [CntW-1:0]  req_limit;
  logic [LimW-1:0]  tok_limit;
  logic             chunk_on;
  logic [TokW-1:0]  chunk_tok;

  logic [TotW-1:0]  tok_total;
  logic [CntW-1:0]  adm_count;
  logic [HintW-1:0] hint_peak;
  logic             full_hold;

  result_t          expected_results[$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic result_t admit_candidate(input candidate_t c, input logic last);
    result_t          r;
    logic [TokW-1:0]  grant;
    logic [TotW:0]    sum;
    logic [HintW-1:0] len;
    logic [CntW-1:0]  lim;
    logic             take;
    logic             hit;
    logic             closed;
    r = '0;
    r.granted_index = c.index;
    if (full_hold) begin
      // The request limit was hit earlier: everything up to the final
      // candidate is ignored and reports zeros.
      if (last) full_hold = 1'b0;
    end else begin
      take  = 1'b0;
      hit   = 1'b0;
      grant = '0;
      sum   = {1'b0, tok_total};
      if (c.replica == own_rep && !c.finished && !c.busy && c.remaining != '0) begin
        grant = c.remaining;
        if (chunk_on && chunk_tok < grant) grant = chunk_tok;
        sum = {1'b0, tok_total} + {{(TotW + 1 - TokW){1'b0}}, grant};
        if (adm_count == '0 || tok_limit == '0 ||
            sum <= {{(TotW + 1 - LimW){1'b0}}, tok_limit}) take = 1'b1;
      end
      if (take) begin
        tok_total = (sum > {1'b0, TotMax}) ? TotMax : sum[TotW-1:0];
        adm_count = adm_count + CntW'(1);
        len = {1'b0, c.prompt} + {1'b0, c.done_out};
        if (len > hint_peak) hint_peak = len;
        lim = (req_limit == '0) ? CntW'(1) : req_limit;
        hit = (adm_count >= lim);
      end else begin
        grant = '0;
      end
      closed = hit || last;
      r.admitted       = take;
      r.granted_tokens = grant;
      r.batch_tokens   = tok_total;
      r.batch_count    = adm_count;
      r.length_hint    = hint_peak;
      r.batch_closed   = closed;
      r.batch_empty    = closed && (adm_count == '0);
      if (closed) begin
        tok_total = '0;
        adm_count = '0;
        hint_peak = '0;
        full_hold = hit && !last;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MaxPrinted)
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result word with nothing pending, index", 64'(out_tdata[15:0]), '0);
    end else begin
      want = expected_results[0];
      expected_results.delete(0);
      if (out_tuser[0] !== want.admitted)
        report_mismatch("admitted", 64'(out_tuser[0]), 64'(want.admitted));
      if (out_tdata[15:0] !== want.granted_index)
        report_mismatch("granted_index", 64'(out_tdata[15:0]), 64'(want.granted_index));
      if (out_tdata[35:16] !== want.granted_tokens)
        report_mismatch("granted_tokens", 64'(out_tdata[35:16]), 64'(want.granted_tokens));
      if (out_tdata[75:36] !== want.batch_tokens)
        report_mismatch("batch_tokens", 64'(out_tdata[75:36]), 64'(want.batch_tokens));
      if (out_tdata[85:76] !== want.batch_count)
        report_mismatch("batch_count", 64'(out_tdata[85:76]), 64'(want.batch_count));
      if (out_tdata[106:86] !== want.length_hint)
        report_mismatch("length_hint", 64'(out_tdata[106:86]), 64'(want.length_hint));
      if (out_tlast !== want.batch_closed)
        report_mismatch("batch_closed", 64'(out_tlast), 64'(want.batch_closed));
      if (out_tuser[1] !== want.batch_empty)
        report_mismatch("batch_empty", 64'(out_tuser[1]), 64'(want.batch_empty));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      own_rep   = OwnReplicaRst;
      req_limit = RequestLimitRst;
      tok_limit = TokenLimitRst;
      chunk_on  = 1'b0;
      chunk_tok = ChunkSizeRst;
      tok_total = '0;
      adm_count = '0;
      hint_peak = '0;
      full_hold = 1'b0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      // The result leaving now can never be the one of the candidate that
      // enters at this edge, so compare first and predict second.
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(),
                                admit_candidate(in_tdata, in_tlast));
      end
      if (cfg_we) begin
        case (cfg_index)
          RegOwnReplica:   own_rep   = cfg_wdata[RepW-1:0];
          RegRequestLimit: req_limit = cfg_wdata[CntW-1:0];
          RegTokenLimit:   tok_limit = cfg_wdata[LimW-1:0];
          RegChunkEnable:  chunk_on  = cfg_wdata[0];
          RegChunkSize:    chunk_tok = cfg_wdata[TokW-1:0];
          default: ;
        endcase
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: tb/tb.sv
// ============================================================================
// tb
// Stimulus and verdict for the prefill batch admission block.
// ============================================================================
// A directed part walks through every reason to skip a candidate, the token
// budget boundary, the first request that always fits, the request limit
// with the ignored stretch that follows it, zero chunk size and the field
// extremes. A random part then runs three idling phases with many register
// settings. The admission checker beside the block predicts and compares;
// this module only drives the block and prints the verdict.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  // Indexes that name no register; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLastUnused  = 3'd7;

  localparam int ItemsPerSetting = 100;
  localparam int SettingsPerPhase = 4;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [CfgDatW-1:0] cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [InDatW-1:0]  in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OutDatW-1:0] out_tdata;
  logic [OutUsrW-1:0] out_tuser;
  logic               out_tlast;

  int mismatch_count;
  int outstanding;

  // Idle percentages of the two sides, changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Settings of the current random segment, used to shape the candidates.
  logic [RepW-1:0] own_now;
  int              rem_max;

  prefill_batch_admission u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  admission_checker u_admission_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, one decision per cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Waits until every predicted result word has come back. The checker's
  // count is registered, which only adds margin.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Writes every register while the block is idle. A write to an index that
  // names no register goes first; it must change nothing.
  task automatic apply_settings(input logic [RepW-1:0] own, input logic [CntW-1:0] req_lim,
                                input logic [LimW-1:0] tok_lim, input logic chunk_en,
                                input logic [TokW-1:0] chunk_sz);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (2) @(posedge clk);
    write_reg(CfgIdxW'($urandom_range(RegFirstUnused, RegLastUnused)), $urandom);
    write_reg(RegOwnReplica, CfgDatW'(own));
    write_reg(RegRequestLimit, CfgDatW'(req_lim));
    write_reg(RegTokenLimit, CfgDatW'(tok_lim));
    write_reg(RegChunkEnable, CfgDatW'(chunk_en));
    write_reg(RegChunkSize, CfgDatW'(chunk_sz));
    cfg_we <= 1'b0;
    own_now = own;
  endtask

  // Offers one candidate word, after a random idle gap, and returns at the
  // edge where it is accepted. tvalid stays high so that a back-to-back
  // word needs no second assignment in the same step.
  task automatic send_candidate(input logic [IdxW-1:0] idx, input logic [RepW-1:0] rep,
                                input logic fin, input logic busy,
                                input logic [TokW-1:0] rem, input logic [TokW-1:0] prompt,
                                input logic [TokW-1:0] done_out, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, done_out, prompt, rem, busy, fin, rep, idx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Draws a register setting. The token budget is often small enough that
  // the greedy fit is decided on real sums, and the remaining counts are
  // scaled to that budget.
  task automatic pick_settings();
    logic [CntW-1:0] req_lim;
    logic [LimW-1:0] tok_lim;
    logic [TokW-1:0] chunk_sz;
    case ($urandom_range(0, 4))
      0: req_lim = '0;
      1: req_lim = CntW'(1);
      2: req_lim = CntW'($urandom_range(2, 6));
      3: req_lim = '1;
      default: req_lim = CntW'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: tok_lim = '0;
      1, 2: tok_lim = LimW'($urandom_range(1, 20000));
      3: tok_lim = '1;
      default: tok_lim = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: chunk_sz = '0;
      1: chunk_sz = TokW'($urandom_range(1, 2000));
      2: chunk_sz = '1;
      default: chunk_sz = TokW'($urandom);
    endcase
    rem_max = (tok_lim != '0 && tok_lim <= 20000) ? int'(tok_lim) / 2 + 1 : 5000;
    apply_settings(RepW'($urandom), req_lim, tok_lim, 1'($urandom_range(0, 1)), chunk_sz);
  endtask

  // Mostly candidates of the own replica that are still eligible, so that
  // batches fill up and hit both limits; the rest is skipped traffic.
  task automatic send_random();
    logic [RepW-1:0] rep;
    logic [TokW-1:0] rem;
    int              pick;
    rep  = ($urandom_range(0, 99) < 80) ? own_now : RepW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5)       rem = '0;
    else if (pick < 60) rem = TokW'($urandom_range(1, rem_max));
    else if (pick < 85) rem = TokW'($urandom_range(1, 4095));
    else                rem = TokW'($urandom);
    send_candidate(IdxW'($urandom), rep, $urandom_range(0, 99) < 8,
                   $urandom_range(0, 99) < 8, rem, TokW'($urandom), TokW'($urandom),
                   $urandom_range(0, 99) < 12);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Budget of 1000 tokens, three requests per batch, no chunking.
    apply_settings(8'h05, 10'd3, 32'd1000, 1'b0, 20'd512);
    // Largest prompt and output counts give the widest length hint.
    send_candidate(16'h0000, 8'h05, 1'b0, 1'b0, 20'd400, '1, '1, 1'b0);
    // Would overrun the budget: rejected.
    send_candidate(16'hFFFF, 8'h05, 1'b0, 1'b0, 20'd700, 20'd1, 20'd2, 1'b0);
    // Lands exactly on the budget: admitted.
    send_candidate(16'h0001, 8'h05, 1'b0, 1'b0, 20'd600, 20'd3, 20'd4, 1'b0);
    // Other replica, finished, already batched, nothing left: all skipped.
    send_candidate(16'h0002, 8'h06, 1'b0, 1'b0, 20'd1, 20'd0, 20'd0, 1'b0);
    send_candidate(16'h0003, 8'h05, 1'b1, 1'b0, 20'd1, 20'd0, 20'd0, 1'b0);
    send_candidate(16'h0004, 8'h05, 1'b0, 1'b1, 20'd1, 20'd0, 20'd0, 1'b0);
    send_candidate(16'h0005, 8'h05, 1'b0, 1'b0, 20'd0, 20'd0, 20'd0, 1'b0);
    // One token past the budget.
    send_candidate(16'h0006, 8'h05, 1'b0, 1'b0, 20'd1, 20'd0, 20'd0, 1'b0);
    // The final candidate closes the batch even though it is skipped.
    send_candidate(16'h0007, 8'h06, 1'b0, 1'b0, 20'd5, 20'd0, 20'd0, 1'b1);
    // A final candidate alone closes an empty batch.
    send_candidate(16'h0008, 8'h05, 1'b1, 1'b1, 20'd0, 20'd0, 20'd0, 1'b1);
    // The first request always fits, even far above the budget.
    send_candidate(16'h0009, 8'h05, 1'b0, 1'b0, '1, 20'd0, 20'd0, 1'b0);
    send_candidate(16'h000A, 8'h05, 1'b0, 1'b0, 20'd1, 20'd0, 20'd0, 1'b1);

    // Request limit zero acts as one, no budget, chunking with chunk size
    // zero grants nothing but still admits.
    apply_settings(8'hFF, 10'd0, 32'd0, 1'b1, 20'd0);
    send_candidate(16'h000B, 8'hFF, 1'b0, 1'b0, '1, 20'd9, 20'd9, 1'b0);
    // The limit was hit before the final candidate: ignored until the final.
    send_candidate(16'h000C, 8'hFF, 1'b0, 1'b0, 20'd5, 20'd1, 20'd1, 1'b0);
    send_candidate(16'h000D, 8'hFF, 1'b0, 1'b0, 20'd5, 20'd1, 20'd1, 1'b1);
    // Limit and final candidate on the same word.
    send_candidate(16'h000E, 8'hFF, 1'b0, 1'b0, 20'd3, 20'd0, 20'd0, 1'b1);

    // Largest request limit, budget and chunk size.
    apply_settings(8'h00, '1, '1, 1'b1, '1);
    send_candidate(16'h000F, 8'h00, 1'b0, 1'b0, '1, '1, 20'd0, 1'b0);
    send_candidate(16'h0010, 8'h00, 1'b0, 1'b0, 20'd7, 20'd0, '1, 1'b1);

    // Chunking below the remaining count, two requests per batch.
    apply_settings(8'h5A, 10'd2, 32'd300, 1'b1, 20'd100);
    send_candidate(16'h0011, 8'h5A, 1'b0, 1'b0, 20'd250, 20'd10, 20'd5, 1'b0);
    send_candidate(16'h0012, 8'h5A, 1'b0, 1'b0, 20'd50, 20'd20, 20'd5, 1'b0);
    send_candidate(16'h0013, 8'h5A, 1'b0, 1'b0, 20'd9, 20'd0, 20'd0, 1'b1);
    send_candidate(16'h0014, 8'h5A, 1'b0, 1'b0, 20'd250, 20'd1, 20'd1, 1'b1);

    // Random part: sender idles more lightly than the receiver, then the
    // other way round, then neither side idles.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SettingsPerPhase; seg++) begin
        pick_settings();
        repeat (ItemsPerSetting) send_random();
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: prefill_batch_admission.f
rtl/pba_pkg.sv
rtl/prefill_batch_admission.sv
tb/admission_checker.sv
tb/tb.sv
